/* src/tsdx_pkg.sv */
// ----------------------------------------------------------------------------
// tsdx_pkg
// Shared types and constants of the time-series delta-of-delta / xor encoder.
// ----------------------------------------------------------------------------
package tsdx_pkg;

    // sample counter and chunk limit
    localparam int          COUNT_W     = 16;
    localparam logic [15:0] MAX_SAMPLES = 16'hFFFF;

    // delta-of-delta code widths and prefixes
    localparam int          DOD14_W     = 14;
    localparam int          DOD17_W     = 17;
    localparam int          DOD20_W     = 20;
    localparam logic [1:0]  PFX_DOD14   = 2'b10;
    localparam logic [2:0]  PFX_DOD17   = 3'b110;
    localparam logic [3:0]  PFX_DOD20   = 4'b1110;
    localparam logic [3:0]  PFX_DOD_BIG = 4'b1111;

    // xor value code prefixes and leading zero cap
    localparam logic [1:0]  PFX_VAL_REUSE = 2'b10;
    localparam logic [1:0]  PFX_VAL_NEW   = 2'b11;
    localparam logic [4:0]  LEAD_CAP      = 5'd31;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // input transaction modes
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_CLOSE  = 1'b1;

    // result kinds
    typedef enum logic [2:0] {
        KIND_FIRST_TIME,
        KIND_FIRST_VALUE,
        KIND_FIRST_DELTA,
        KIND_BITSTREAM,
        KIND_COUNT
    } field_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_BACKWARDS
    } field_status_t;

    // what an accepted input turned into
    typedef enum logic [2:0] {
        JOB_CLOSE,
        JOB_FULL,
        JOB_BACKWARDS,
        JOB_FIRST,
        JOB_SECOND,
        JOB_LATER
    } job_code_t;

    // timestamp code class
    typedef enum logic [2:0] {
        TC_ZERO,
        TC_W14,
        TC_W17,
        TC_W20,
        TC_WIDE
    } tcode_t;

    // value code class
    typedef enum logic [1:0] {
        VC_ZERO,
        VC_REUSE,
        VC_NEW
    } vcode_t;

    // classified sample after the first front stage
    typedef struct packed {
        job_code_t   code;
        logic [63:0] w0;    // timestamp, delta or count
        logic [63:0] w1;    // raw value or xor
    } a_job_t;

    // fully classified sample handed to the back end
    typedef struct packed {
        job_code_t   code;
        logic [63:0] w0;    // timestamp, delta, dod or count
        logic [63:0] w1;    // raw value or xor
        tcode_t      tcode;
        vcode_t      vcode;
        logic [4:0]  lead;
        logic [5:0]  trail;
        logic [6:0]  vlen;  // significant bits of the xor field
    } job_t;

    // leading zeros of a nonzero word, binary search
    function automatic logic [5:0] lead_zero_count(input logic [63:0] v);
        logic [63:0] w;
        logic [5:0]  n;
        w = v;
        n = '0;
        for (int s = 5; s >= 0; s--)
        begin
            if ((w & ~(ALL_ONES >> (1 << s))) == '0)
            begin
                n[s] = 1'b1;
                w    = w << (1 << s);
            end
        end
        return n;
    endfunction

    // trailing zeros of a nonzero word, binary search
    function automatic logic [5:0] trail_zero_count(input logic [63:0] v);
        logic [63:0] w;
        logic [5:0]  n;
        w = v;
        n = '0;
        for (int s = 5; s >= 0; s--)
        begin
            if ((w & (ALL_ONES >> (64 - (1 << s)))) == '0)
            begin
                n[s] = 1'b1;
                w    = w >> (1 << s);
            end
        end
        return n;
    endfunction

endpackage

/* src/timeseries_dod_xor_encoder.sv */
// ----------------------------------------------------------------------------
// timeseries_dod_xor_encoder
// Time-series sample encoder: delta-of-delta timestamps and xor values,
// emitted as tagged fields for a downstream serializer.
// ----------------------------------------------------------------------------
// path: an accepted sample passes the two front stages, the queue write and
//   the output register before its first field leaves
// throughput: one field per cycle out of the single output register while
//   m_tready is high, a sample giving 1 to 4 fields; input taken every cycle
//   while the four-entry queue has room
// reset: asynchronous, clears chunk state, window and all valid flags
module timeseries_dod_xor_encoder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // sample_time[63:0], sample_bits[127:64]
    input  logic [0:0]   s_tuser,   // mode[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // field_bits[63:0], field_len[70:64], status[72:71]
    output logic [2:0]   m_tuser,   // kind[2:0]
    output logic         m_tlast
);
    import tsdx_pkg::*;

    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    job_t head;
    logic empty;

    tsdx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .mode        (s_tuser[0]),
        .sample_time (s_tdata[63:0]),
        .sample_bits (s_tdata[127:64]),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    tsdx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    tsdx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/tsdx_front.sv */
// ----------------------------------------------------------------------------
// tsdx_front
// Two-stage front end: takes samples, tracks chunk state, computes deltas,
// delta-of-delta, xor and the zero window, and hands finished jobs to a queue.
// ----------------------------------------------------------------------------
module tsdx_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                mode,
    input  logic [63:0]         sample_time,
    input  logic [63:0]         sample_bits,
    output logic                push,
    output tsdx_pkg::job_t      push_job,
    input  logic                q_full
);
    import tsdx_pkg::*;

    // stage a state
    logic               a_valid_reg, a_valid_next;
    a_job_t             a_job_reg, a_job_next;
    logic [63:0]        prior_time_reg, prior_time_next;
    logic [63:0]        prior_value_reg, prior_value_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // stage b state
    logic               b_valid_reg, b_valid_next;
    job_t               b_job_reg, b_job_next;
    logic [63:0]        prior_delta_reg, prior_delta_next;
    logic [4:0]         win_lead_reg, win_lead_next;
    logic [5:0]         win_trail_reg, win_trail_next;
    logic               win_valid_reg, win_valid_next;

    logic               accept;
    logic               a_move;
    logic               b_free;

    logic [63:0]        dod;
    logic [63:0]        dod_m1;
    logic [63:0]        x;
    logic [5:0]         lz_raw;
    logic [4:0]         lz;
    logic [5:0]         tz;
    logic               reuse;
    logic               fits14, fits17, fits20;

    // handshake between stages
    always_comb
    begin
        push     = b_valid_reg && !q_full;
        b_free   = !b_valid_reg || !q_full;
        a_move   = a_valid_reg && b_free;
        s_tready = !a_valid_reg || b_free;
        accept   = s_tvalid && s_tready;
        push_job = b_job_reg;
    end

    // stage a: classify the sample and update chunk state
    always_comb
    begin
        a_job_next       = a_job_reg;
        prior_time_next  = prior_time_reg;
        prior_value_next = prior_value_reg;
        count_next       = count_reg;
        a_valid_next     = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
        if (accept)
        begin
            a_job_next.w0 = '0;
            a_job_next.w1 = '0;
            if (mode == MODE_CLOSE)
            begin
                a_job_next.code  = JOB_CLOSE;
                a_job_next.w0    = 64'(count_reg);
                prior_time_next  = '0;
                prior_value_next = '0;
                count_next       = '0;
            end
            else if (count_reg == MAX_SAMPLES)
            begin
                a_job_next.code = JOB_FULL;
            end
            else if (count_reg == '0)
            begin
                a_job_next.code  = JOB_FIRST;
                a_job_next.w0    = sample_time;
                a_job_next.w1    = sample_bits;
                prior_time_next  = sample_time;
                prior_value_next = sample_bits;
                count_next       = count_reg + 1'b1;
            end
            else if (count_reg == COUNT_W'(1)
                     && $signed(sample_time) < $signed(prior_time_reg))
            begin
                a_job_next.code = JOB_BACKWARDS;
            end
            else
            begin
                a_job_next.code  = (count_reg == COUNT_W'(1)) ? JOB_SECOND : JOB_LATER;
                a_job_next.w0    = sample_time - prior_time_reg;
                a_job_next.w1    = sample_bits ^ prior_value_reg;
                prior_time_next  = sample_time;
                prior_value_next = sample_bits;
                count_next       = count_reg + 1'b1;
            end
        end
    end

    // stage b: delta-of-delta class and range checks
    always_comb
    begin
        dod    = a_job_reg.w0 - prior_delta_reg;
        dod_m1 = a_job_reg.w0 + ~prior_delta_reg;
        fits14 = (dod_m1[63:DOD14_W-1] == '0) || (dod_m1[63:DOD14_W-1] == '1);
        fits17 = (dod_m1[63:DOD17_W-1] == '0) || (dod_m1[63:DOD17_W-1] == '1);
        fits20 = (dod_m1[63:DOD20_W-1] == '0) || (dod_m1[63:DOD20_W-1] == '1);
    end

    // stage b: xor window
    always_comb
    begin
        x      = a_job_reg.w1;
        lz_raw = lead_zero_count(x);
        lz     = (lz_raw > 6'(LEAD_CAP)) ? LEAD_CAP : lz_raw[4:0];
        tz     = trail_zero_count(x);
        reuse  = win_valid_reg && (lz >= win_lead_reg) && (tz >= win_trail_reg);
    end

    // stage b: build the job and update delta and window state
    always_comb
    begin
        b_job_next       = b_job_reg;
        prior_delta_next = prior_delta_reg;
        win_lead_next    = win_lead_reg;
        win_trail_next   = win_trail_reg;
        win_valid_next   = win_valid_reg;
        b_valid_next     = a_move ? 1'b1 : (push ? 1'b0 : b_valid_reg);
        if (a_move)
        begin
            b_job_next.code  = a_job_reg.code;
            b_job_next.w0    = a_job_reg.w0;
            b_job_next.w1    = a_job_reg.w1;
            b_job_next.tcode = TC_ZERO;
            b_job_next.vcode = VC_ZERO;
            b_job_next.lead  = '0;
            b_job_next.trail = '0;
            b_job_next.vlen  = '0;
            case (a_job_reg.code)
                JOB_CLOSE:
                begin
                    prior_delta_next = '0;
                    win_lead_next    = '0;
                    win_trail_next   = '0;
                    win_valid_next   = 1'b0;
                end
                JOB_SECOND, JOB_LATER:
                begin
                    prior_delta_next = a_job_reg.w0;
                    if (a_job_reg.code == JOB_LATER)
                    begin
                        b_job_next.w0 = dod;
                        if (dod == '0)
                            b_job_next.tcode = TC_ZERO;
                        else if (fits14)
                            b_job_next.tcode = TC_W14;
                        else if (fits17)
                            b_job_next.tcode = TC_W17;
                        else if (fits20)
                            b_job_next.tcode = TC_W20;
                        else
                            b_job_next.tcode = TC_WIDE;
                    end
                    if (x == '0)
                    begin
                        b_job_next.vcode = VC_ZERO;
                    end
                    else if (reuse)
                    begin
                        b_job_next.vcode = VC_REUSE;
                        b_job_next.lead  = win_lead_reg;
                        b_job_next.trail = win_trail_reg;
                        b_job_next.vlen  = 7'd64 - {2'b00, win_lead_reg}
                                           - {1'b0, win_trail_reg};
                    end
                    else
                    begin
                        b_job_next.vcode = VC_NEW;
                        b_job_next.lead  = lz;
                        b_job_next.trail = tz;
                        b_job_next.vlen  = 7'd64 - {2'b00, lz} - {1'b0, tz};
                        win_lead_next    = lz;
                        win_trail_next   = tz;
                        win_valid_next   = 1'b1;
                    end
                end
                default:
                begin
                    b_job_next.code = a_job_reg.code;
                end
            endcase
        end
    end

    // control and chunk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            prior_time_reg  <= '0;
            prior_value_reg <= '0;
            count_reg       <= '0;
            prior_delta_reg <= '0;
            win_lead_reg    <= '0;
            win_trail_reg   <= '0;
            win_valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= a_valid_next;
            b_valid_reg     <= b_valid_next;
            prior_time_reg  <= prior_time_next;
            prior_value_reg <= prior_value_next;
            count_reg       <= count_next;
            prior_delta_reg <= prior_delta_next;
            win_lead_reg    <= win_lead_next;
            win_trail_reg   <= win_trail_next;
            win_valid_reg   <= win_valid_next;
        end
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        a_job_reg <= a_job_next;
        b_job_reg <= b_job_next;
    end

`ifndef ASSERT_OFF
    // a close passing stage b clears the window
    a_close_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        (a_move && a_job_reg.code == JOB_CLOSE) |=> !win_valid_reg)
        else $error("window still valid after close");

    // a finished job waits in stage b while the queue is full
    a_job_held_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && q_full) |=> (b_valid_reg && $stable(b_job_reg)))
        else $error("stage b job lost while queue full");
`endif

endmodule

/* src/tsdx_queue.sv */
// ----------------------------------------------------------------------------
// tsdx_queue
// Small job queue that decouples the front end from the field emitter.
// ----------------------------------------------------------------------------
module tsdx_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsdx_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output tsdx_pkg::job_t  head,
    output logic            empty
);
    import tsdx_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // status and head
    always_comb
    begin
        full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        empty = (count_reg == '0);
        head  = entry_reg[rd_ptr_reg];
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

`ifndef ASSERT_OFF
    // no write into a full queue
    q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    // no read from an empty queue
    q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

/* src/tsdx_back.sv */
// ----------------------------------------------------------------------------
// tsdx_back
// Field emitter: walks the queued job and sends one tagged field per cycle
// through a registered output stage while the receiver is ready.
// ----------------------------------------------------------------------------
module tsdx_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tsdx_pkg::job_t  head,
    input  logic            empty,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [79:0]     m_tdata,   // field_bits[63:0], field_len[70:64], status[72:71]
    output logic [2:0]      m_tuser,   // kind[2:0]
    output logic            m_tlast
);
    import tsdx_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  len_reg, len_next;
    logic [1:0]  status_reg, status_next;
    logic        last_reg, last_next;
    logic [1:0]  idx_reg, idx_next;

    logic        load;
    logic [2:0]  n_time;
    logic [2:0]  n_value;
    logic [2:0]  n_fields;
    logic        last_field;
    logic [1:0]  vidx;
    logic [2:0]  f_kind;
    logic [63:0] f_bits;
    logic [6:0]  f_len;
    logic [1:0]  f_status;

    // field count of the head job
    always_comb
    begin
        n_time  = (head.code == JOB_LATER && head.tcode == TC_WIDE) ? 3'd2 : 3'd1;
        n_value = (head.vcode == VC_ZERO) ? 3'd1 : 3'd2;
        case (head.code)
            JOB_FIRST:               n_fields = 3'd2;
            JOB_SECOND, JOB_LATER:   n_fields = n_time + n_value;
            default:                 n_fields = 3'd1;
        endcase
        last_field = ({1'b0, idx_reg} == n_fields - 3'd1);
        vidx       = idx_reg - n_time[1:0];
    end

    // select the field at the current step
    always_comb
    begin
        f_kind   = KIND_BITSTREAM;
        f_bits   = '0;
        f_len    = '0;
        f_status = STATUS_OK;
        case (head.code)
            JOB_CLOSE:
            begin
                f_kind = KIND_COUNT;
                f_bits = head.w0;
                f_len  = 7'(COUNT_W);
            end
            JOB_FULL:
            begin
                f_status = STATUS_FULL;
            end
            JOB_BACKWARDS:
            begin
                f_kind   = KIND_FIRST_DELTA;
                f_status = STATUS_BACKWARDS;
            end
            JOB_FIRST:
            begin
                f_kind = (idx_reg == 2'd0) ? KIND_FIRST_TIME : KIND_FIRST_VALUE;
                f_bits = (idx_reg == 2'd0) ? head.w0 : head.w1;
                f_len  = 7'd64;
            end
            JOB_SECOND, JOB_LATER:
            begin
                if ({1'b0, idx_reg} < n_time)
                begin
                    // timestamp part
                    if (head.code == JOB_SECOND)
                    begin
                        f_kind = KIND_FIRST_DELTA;
                        f_bits = head.w0;
                        f_len  = 7'd64;
                    end
                    else if (idx_reg == 2'd1)
                    begin
                        f_bits = head.w0;
                        f_len  = 7'd64;
                    end
                    else
                    begin
                        case (head.tcode)
                            TC_ZERO:
                            begin
                                f_bits = '0;
                                f_len  = 7'd1;
                            end
                            TC_W14:
                            begin
                                f_bits = (64'(PFX_DOD14) << DOD14_W)
                                         | 64'(head.w0[DOD14_W-1:0]);
                                f_len  = 7'(DOD14_W + 2);
                            end
                            TC_W17:
                            begin
                                f_bits = (64'(PFX_DOD17) << DOD17_W)
                                         | 64'(head.w0[DOD17_W-1:0]);
                                f_len  = 7'(DOD17_W + 3);
                            end
                            TC_W20:
                            begin
                                f_bits = (64'(PFX_DOD20) << DOD20_W)
                                         | 64'(head.w0[DOD20_W-1:0]);
                                f_len  = 7'(DOD20_W + 4);
                            end
                            default:
                            begin
                                f_bits = 64'(PFX_DOD_BIG);
                                f_len  = 7'd4;
                            end
                        endcase
                    end
                end
                else if (vidx == 2'd0)
                begin
                    // value header
                    case (head.vcode)
                        VC_REUSE:
                        begin
                            f_bits = 64'(PFX_VAL_REUSE);
                            f_len  = 7'd2;
                        end
                        VC_NEW:
                        begin
                            f_bits = 64'({PFX_VAL_NEW, head.lead, head.vlen[5:0]});
                            f_len  = 7'd13;
                        end
                        default:
                        begin
                            f_bits = '0;
                            f_len  = 7'd1;
                        end
                    endcase
                end
                else
                begin
                    // meaningful xor bits
                    f_bits = head.w1 >> head.trail;
                    f_len  = head.vlen;
                end
            end
            default:
            begin
                f_kind = KIND_BITSTREAM;
            end
        endcase
    end

    // output stage and step counter
    always_comb
    begin
        load           = !empty && (!out_valid_reg || m_tready);
        pop            = load && last_field;
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (load)
        begin
            idx_next    = last_field ? 2'd0 : idx_reg + 1'b1;
            kind_next   = f_kind;
            bits_next   = f_bits;
            len_next    = f_len;
            status_next = f_status;
            last_next   = last_field;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        bits_reg   <= bits_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // port mapping
    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = {7'd0, status_reg, len_reg, bits_reg};
        m_tuser  = kind_reg;
        m_tlast  = last_reg;
    end

`ifndef ASSERT_OFF
    // the step counter never runs past the fields of the head job
    b_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, idx_reg} < n_fields))
        else $error("field step beyond job");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time-series delta-of-delta / xor encoder.
// A clocked driver sends samples and chunk closes from a queue, predicts the
// tagged fields that each accepted transaction must produce, and a clocked
// monitor compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsdx_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_START     = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 380;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_TOGGLE,
        RX_RUNS
    } rx_style_t;

    typedef struct {
        field_kind_t   kind;
        logic [63:0]   bits;
        logic [6:0]    len;
        field_status_t status;
        logic          last;
    } enc_field_t;

    typedef struct {
        logic        mode;
        logic [63:0] stamp;
        logic [63:0] value;
        bit          settle;    // hold until every predicted field has arrived
    } sample_item_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block ports
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;    // sample_time[63:0], sample_bits[127:64]
    logic [0:0]   s_tuser  = '0;    // mode[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;          // field_bits[63:0], field_len[70:64], status[72:71]
    logic [2:0]   m_tuser;          // kind[2:0]
    logic         m_tlast;

    timeseries_dod_xor_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // encoder state as the predictor sees it
    logic [63:0] enc_prev_time  = '0;
    logic [63:0] enc_prev_delta = '0;
    logic [63:0] enc_prev_value = '0;
    logic [4:0]  enc_win_lead   = '0;
    logic [5:0]  enc_win_trail  = '0;
    logic        enc_win_valid  = 1'b0;
    logic [15:0] enc_count      = '0;

    // fields of the sample being predicted
    enc_field_t  sample_fields [4];
    int          sample_nf;

    enc_field_t   expected_fields [$];
    sample_item_t samples_to_send [$];

    int fields_expected = 0;
    int fields_seen     = 0;
    int errors          = 0;
    int samples_sent    = 0;
    int closes          = 0;
    int full_hits       = 0;
    int backwards_hits  = 0;
    int wide_dods       = 0;
    int window_reuses   = 0;
    int cycle_count     = 0;

    // stimulus generator state
    logic [63:0] gen_time  = '0;
    logic [63:0] gen_delta = '0;
    logic [63:0] gen_value = '0;
    int          gen_shift = 0;

    longint boundary_dods [12] = '{0, 8192, -8191, -8192, 8193, 65536, 65537, -65535,
                                   524288, -524287, 524289, -524288};
    logic [63:0] boundary_flips [12] = '{
        64'h0, 64'h2, 64'h1_0000, 64'h0,
        64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0FF0_0000_0000, 64'h0000_0180_0000_0000, 64'h0, 64'h8000_0000_0000_0001
    };

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] low_bits_mask(input int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic int leading_zeros(input logic [63:0] w);
        int n;
        n = 0;
        while (n < 64 && !w[63 - n])
            n++;
        return n;
    endfunction

    function automatic int trailing_zeros(input logic [63:0] w);
        int n;
        n = 0;
        while (n < 64 && !w[n])
            n++;
        return n;
    endfunction

    // adjusted two's complement range of w bits: -(2^(w-1)-1) .. 2^(w-1)
    function automatic bit dod_fits(input logic [63:0] dod, input int w);
        longint sd;
        longint half;
        sd   = dod;
        half = longint'(1) << (w - 1);
        return (sd >= 1 - half) && (sd <= half);
    endfunction

    function automatic void add_field(input field_kind_t k, input logic [63:0] b,
                                      input int len, input field_status_t s);
        sample_fields[sample_nf] = '{k, b, 7'(len), s, 1'b0};
        sample_nf++;
    endfunction

    function automatic void predict_time_code(input logic [63:0] stamp);
        logic [63:0] delta;
        logic [63:0] dod;
        delta          = stamp - enc_prev_time;
        dod            = delta - enc_prev_delta;
        enc_prev_delta = delta;
        if (dod == '0)
            add_field(KIND_BITSTREAM, 64'd0, 1, STATUS_OK);
        else if (dod_fits(dod, DOD14_W))
            add_field(KIND_BITSTREAM,
                      (64'(PFX_DOD14) << DOD14_W) | (dod & low_bits_mask(DOD14_W)),
                      DOD14_W + 2, STATUS_OK);
        else if (dod_fits(dod, DOD17_W))
            add_field(KIND_BITSTREAM,
                      (64'(PFX_DOD17) << DOD17_W) | (dod & low_bits_mask(DOD17_W)),
                      DOD17_W + 3, STATUS_OK);
        else if (dod_fits(dod, DOD20_W))
            add_field(KIND_BITSTREAM,
                      (64'(PFX_DOD20) << DOD20_W) | (dod & low_bits_mask(DOD20_W)),
                      DOD20_W + 4, STATUS_OK);
        else
        begin
            add_field(KIND_BITSTREAM, 64'(PFX_DOD_BIG), 4, STATUS_OK);
            add_field(KIND_BITSTREAM, dod, 64, STATUS_OK);
            wide_dods++;
        end
    endfunction

    function automatic void predict_value_code(input logic [63:0] value);
        logic [63:0] x;
        int lz;
        int tz;
        int len;
        x = value ^ enc_prev_value;
        if (x == '0)
            add_field(KIND_BITSTREAM, 64'd0, 1, STATUS_OK);
        else
        begin
            lz = leading_zeros(x);
            tz = trailing_zeros(x);
            if (lz > LEAD_CAP)
                lz = LEAD_CAP;
            if (enc_win_valid && lz >= enc_win_lead && tz >= enc_win_trail)
            begin
                // xor fits inside the current window
                len = 64 - int'(enc_win_lead) - int'(enc_win_trail);
                add_field(KIND_BITSTREAM, 64'(PFX_VAL_REUSE), 2, STATUS_OK);
                add_field(KIND_BITSTREAM, (x >> enc_win_trail) & low_bits_mask(len), len,
                          STATUS_OK);
                window_reuses++;
            end
            else
            begin
                // new window, significant count of 64 wraps to 0 in the header
                enc_win_lead  = 5'(lz);
                enc_win_trail = 6'(tz);
                enc_win_valid = 1'b1;
                len = 64 - lz - tz;
                add_field(KIND_BITSTREAM,
                          (64'(PFX_VAL_NEW) << 11) | (64'(lz) << 6) | 64'(len & 63), 13,
                          STATUS_OK);
                add_field(KIND_BITSTREAM, (x >> tz) & low_bits_mask(len), len, STATUS_OK);
            end
        end
    endfunction

    function automatic void predict_encoding(input logic mode, input logic [63:0] stamp,
                                             input logic [63:0] value);
        bit stored;
        enc_field_t f;
        sample_nf = 0;
        stored    = 1'b0;
        if (mode == MODE_CLOSE)
        begin
            // count out, then back to an empty chunk
            add_field(KIND_COUNT, 64'(enc_count), COUNT_W, STATUS_OK);
            enc_prev_time  = '0;
            enc_prev_delta = '0;
            enc_prev_value = '0;
            enc_win_lead   = '0;
            enc_win_trail  = '0;
            enc_win_valid  = 1'b0;
            enc_count      = '0;
            closes++;
        end
        else if (enc_count >= MAX_SAMPLES)
        begin
            add_field(KIND_BITSTREAM, 64'd0, 0, STATUS_FULL);
            full_hits++;
        end
        else if (enc_count == 16'd0)
        begin
            add_field(KIND_FIRST_TIME, stamp, 64, STATUS_OK);
            add_field(KIND_FIRST_VALUE, value, 64, STATUS_OK);
            stored = 1'b1;
        end
        else if (enc_count == 16'd1 && $signed(stamp) < $signed(enc_prev_time))
        begin
            add_field(KIND_FIRST_DELTA, 64'd0, 0, STATUS_BACKWARDS);
            backwards_hits++;
        end
        else
        begin
            if (enc_count == 16'd1)
            begin
                enc_prev_delta = stamp - enc_prev_time;
                add_field(KIND_FIRST_DELTA, enc_prev_delta, 64, STATUS_OK);
            end
            else
                predict_time_code(stamp);
            predict_value_code(value);
            stored = 1'b1;
        end

        if (stored)
        begin
            enc_prev_time  = stamp;
            enc_prev_value = value;
            enc_count      = enc_count + 16'd1;
        end

        for (int i = 0; i < sample_nf; i++)
        begin
            f      = sample_fields[i];
            f.last = (i == sample_nf - 1);
            expected_fields.push_back(f);
        end
        fields_expected += sample_nf;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_sample(input logic mode, input logic [63:0] stamp,
                                         input logic [63:0] value, input bit settle);
        sample_item_t s;
        s = '{mode, stamp, value, settle};
        samples_to_send.push_back(s);
    endfunction

    function automatic void gen_start(input logic [63:0] stamp, input logic [63:0] value,
                                      input logic [63:0] delta, input bit settle);
        gen_time  = stamp;
        gen_value = value;
        gen_delta = delta;
        queue_sample(MODE_APPEND, stamp, value, settle);
    endfunction

    function automatic void gen_append(input logic [63:0] change, input logic [63:0] flip);
        gen_delta = gen_delta + change;
        gen_time  = gen_time + gen_delta;
        gen_value = gen_value ^ flip;
        queue_sample(MODE_APPEND, gen_time, gen_value, 1'b0);
    endfunction

    function automatic logic [63:0] random_dod();
        case ($urandom_range(0, 9))
            0, 1, 2: return 64'd0;
            3, 4:    return 64'(longint'($urandom_range(0, 16383)) - 8191);
            5:       return 64'(longint'($urandom_range(0, 131071)) - 65535);
            6:       return 64'(longint'($urandom_range(0, 1048575)) - 524287);
            7:       return {$urandom, $urandom};
            default: return 64'(longint'($urandom_range(0, 100)) - 50);
        endcase
    endfunction

    function automatic logic [63:0] random_flip();
        case ($urandom_range(0, 9))
            0, 1, 2: return 64'd0;
            3, 4:    return 64'($urandom_range(1, 255)) << gen_shift;
            5, 6:    return {$urandom, $urandom} & 64'h000F_FFFF_FFFF_FFFF;
            7:       return {$urandom, $urandom};
            8:       return 64'd1 << $urandom_range(0, 63);
            default: return 64'($urandom_range(1, 255)) << 56;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts with random gaps, predicts each accepted transaction
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t nxt;
        bit offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                predict_encoding(s_tuser[0], s_tdata[63:0], s_tdata[127:64]);
                samples_sent++;
            end
            offer = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (samples_to_send.size() > 0 &&
                     (!samples_to_send[0].settle || fields_seen == fields_expected))
            begin
                nxt = samples_to_send.pop_front();
                s_tdata <= {nxt.value, nxt.stamp};
                s_tuser <= nxt.mode;
                offer = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // receiver: changing stall styles plus one long hold-off
    // ------------------------------------------------------------------
    int        rx_cycles     = 0;
    int        rx_phase_left = 0;
    int        rx_run_left   = 0;
    logic      rx_run_ready  = 1'b1;
    rx_style_t rx_style      = RX_STEADY;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_phase_left == 0)
            begin
                rx_style      = rx_style_t'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(32, 255);
            end
            else
                rx_phase_left--;

            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else
            begin
                case (rx_style)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
                    RX_TOGGLE: m_tready <= ~m_tready;
                    default:
                    begin
                        if (rx_run_left == 0)
                        begin
                            rx_run_ready = ~rx_run_ready;
                            rx_run_left  = $urandom_range(1, 6);
                        end
                        else
                            rx_run_left--;
                        m_tready <= rx_run_ready;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each output transaction with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        enc_field_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            fields_seen <= fields_seen + 1;
            if (expected_fields.size() == 0)
            begin
                $error("unexpected field: kind %0d bits %0h", m_tuser, m_tdata[63:0]);
                errors++;
            end
            else
            begin
                want = expected_fields.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_tuser));
                check_field("field_bits", want.bits, m_tdata[63:0]);
                check_field("field_len", 64'(want.len), 64'(m_tdata[70:64]));
                check_field("status", 64'(want.status), 64'(m_tdata[72:71]));
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout with %0d fields outstanding", fields_expected - fields_seen);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int directed_n;
        int chunk_len;

        // empty chunk close right after reset
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);
        // timestamp extremes: first delta wraps, xor spans all 64 bits
        queue_sample(MODE_APPEND, 64'h8000_0000_0000_0000, 64'h0, 1'b0);
        queue_sample(MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 1'b0);
        // dod wraps to a wide code, xor reuses the full-width window
        queue_sample(MODE_APPEND, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_sample(MODE_CLOSE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

        // dod code boundaries and value window cases
        gen_start(64'd1000, 64'h4059_0000_0000_0000, 64'd10, 1'b0);
        gen_append(64'd0, 64'h1);
        for (int i = 0; i < 12; i++)
            gen_append(64'(boundary_dods[i]), boundary_flips[i]);
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);

        // second timestamp going backwards, then an equal one
        queue_sample(MODE_APPEND, 64'd100, 64'h1, 1'b1);
        queue_sample(MODE_APPEND, 64'd99, 64'h2, 1'b0);
        queue_sample(MODE_APPEND, 64'd100, 64'h3, 1'b0);
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);
        directed_n = samples_to_send.size();

        // random chunks: mostly well formed, some noise
        while (samples_to_send.size() < directed_n + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:
                    queue_sample(MODE_CLOSE, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
                1:
                begin
                    chunk_len = $urandom_range(2, 6);
                    for (int i = 0; i < chunk_len; i++)
                        queue_sample(1'($urandom_range(0, 1)), {$urandom, $urandom},
                                     {$urandom, $urandom}, 1'b0);
                end
                default:
                begin
                    gen_shift = $urandom_range(0, 56);
                    gen_start(($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom),
                              {$urandom, $urandom},
                              ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                          : 64'($urandom_range(1, 60000)),
                              ($urandom_range(0, 39) == 0));
                    if ($urandom_range(0, 7) == 0)
                        queue_sample(MODE_APPEND, gen_time - 64'($urandom_range(1, 1000)),
                                     {$urandom, $urandom}, 1'b0);
                    chunk_len = $urandom_range(1, 40);
                    for (int i = 0; i < chunk_len; i++)
                        gen_append((i == 0) ? 64'd0 : random_dod(), random_flip());
                    queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);
                end
            endcase
        end

        // fill one chunk to the sample limit, then refused appends
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b1);
        for (int k = 0; k < MAX_SAMPLES; k++)
            queue_sample(MODE_APPEND, 64'(k) * 64'd15, 64'h3FF0_0000_0000_0000, 1'b0);
        queue_sample(MODE_APPEND, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        queue_sample(MODE_APPEND, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);
        // chunk restarts cleanly after the full one
        gen_start(64'd5, 64'h1, 64'd7, 1'b0);
        gen_append(64'd0, 64'h10);
        gen_append(64'd3, 64'h0);
        queue_sample(MODE_CLOSE, 64'd0, 64'd0, 1'b0);

        // reset
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // wait for all stimulus, then for every predicted field
        @(posedge clk);
        while (samples_to_send.size() != 0 || s_tvalid)
            @(posedge clk);
        while (fields_seen != fields_expected)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_fields.size() != 0)
        begin
            $error("%0d predicted fields never arrived", expected_fields.size());
            errors++;
        end

        $display("Covered %0d input transactions, %0d chunk closes, %0d output fields",
                 samples_sent, closes, fields_seen);
        $display("Refused appends %0d, backward timestamps %0d, wide dods %0d, window reuses %0d",
                 full_hits, backwards_hits, wide_dods, window_reuses);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
